FILE: design/bresenham_line_rasterizer_macros.svh
// assertion macros for the line rasterizer back end
// no dependencies; included by files that carry assertions
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS
`define BLR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/blr_pkg.sv
// package for the line rasterizer: widths, codes and shared types
// no dependencies
package blr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int WIDTH_BITS  = 13;
  localparam int ADDR_BITS   = 32;
  localparam int COLOR_BITS  = 32;
  localparam int DATA_BITS   = 32;
  localparam int PADDR_BITS  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_BASE  = 1'b1;

  localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(640);
  localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RESET  = '0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    logic                  is_start;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    coord_t                abs_dx;
    coord_t                abs_dy;
    logic                  x_neg;
    logic                  y_neg;
    err_t                  err;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] frame_width;
    logic [ADDR_BITS-1:0]  frame_base;
  } cfg_t;

endpackage

FILE: design/blr_regs.sv
// configuration registers behind the apb-style port
// depends on blr_pkg
module blr_regs
  import blr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [WIDTH_BITS-1:0] frame_width;
  logic [ADDR_BITS-1:0]  frame_base;
  logic                  wr_en;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
      frame_base  <= FRAME_BASE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH: frame_width <= pwdata[WIDTH_BITS-1:0];
        REG_FRAME_BASE:  frame_base  <= pwdata[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH: prdata = DATA_BITS'(frame_width);
      REG_FRAME_BASE:  prdata = DATA_BITS'(frame_base);
      default:         prdata = '0;
    endcase
  end

  assign cfg.frame_width = frame_width;
  assign cfg.frame_base  = frame_base;

endmodule

FILE: design/blr_front.sv
// front end: accepts input words, classifies them and sets up line deltas
// depends on blr_pkg
module blr_front
  import blr_pkg::*;
(
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  coord_t                start_x,
  input  coord_t                start_y,
  input  coord_t                end_x,
  input  coord_t                end_y,
  input  logic [COLOR_BITS-1:0] line_color,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  cmd
);

  logic x_lt;
  logic y_lt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign x_lt = start_x < end_x;
  assign y_lt = start_y < end_y;

  always_comb begin
    cmd.is_start = (op == OP_START);
    cmd.x0       = start_x;
    cmd.y0       = start_y;
    cmd.x1       = end_x;
    cmd.y1       = end_y;
    cmd.abs_dx   = x_lt ? (end_x - start_x) : (start_x - end_x);
    cmd.abs_dy   = y_lt ? (end_y - start_y) : (start_y - end_y);
    cmd.x_neg    = !x_lt;
    cmd.y_neg    = !y_lt;
    cmd.err      = err_t'(ERR_BITS'(cmd.abs_dx) - ERR_BITS'(cmd.abs_dy));
    cmd.color    = line_color;
  end

endmodule

FILE: design/blr_queue.sv
// short command queue between front and back end
// depends on blr_pkg
module blr_queue
  import blr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !do_pop) count <= count + CNT_BITS'(1);
      else if (!push && do_pop) count <= count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

FILE: design/blr_back.sv
// back end: bresenham stepping, pixel address pipeline and output register
// depends on blr_pkg and bresenham_line_rasterizer_macros.svh
`include "bresenham_line_rasterizer_macros.svh"
module blr_back
  import blr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output coord_t                pixel_x,
  output coord_t                pixel_y,
  output logic [ADDR_BITS-1:0]  pixel_address,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel
);

  localparam int E2_BITS   = ERR_BITS + 1;
  localparam int PROD_BITS = WIDTH_BITS + COORD_BITS;

  coord_t                cur_x;
  coord_t                cur_y;
  coord_t                target_x;
  coord_t                target_y;
  coord_t                abs_dx;
  coord_t                abs_dy;
  logic                  x_step_negative;
  logic                  y_step_negative;
  err_t                  error_term;
  logic [COLOR_BITS-1:0] held_color;
  logic                  busy;

  logic                  s1_valid;
  coord_t                s1_x;
  coord_t                s1_y;
  logic [COLOR_BITS-1:0] s1_color;
  logic                  s1_last;
  logic [ADDR_BITS-1:0]  s1_prod;
  logic [ADDR_BITS-1:0]  s1_base4x;

  logic                  out_en;
  logic                  s1_en;
  logic                  emit;
  logic                  at_end;
  logic                  step_x;
  logic                  step_y;
  logic signed [E2_BITS-1:0] e2;
  logic signed [E2_BITS-1:0] dx_ext;
  logic signed [E2_BITS-1:0] dy_ext;
  err_t                  error_term_next;
  logic [PROD_BITS-1:0]  prod_full;

  assign out_en = !out_valid || !out_stall;
  assign s1_en  = !s1_valid || out_en;
  assign pop    = q_valid && s1_en;
  assign emit   = pop && !q_cmd.is_start && busy;
  assign at_end = (cur_x == target_x) && (cur_y == target_y);

  assign e2     = {error_term, 1'b0};
  assign dx_ext = $signed(E2_BITS'(abs_dx));
  assign dy_ext = $signed(E2_BITS'(abs_dy));
  assign step_x = e2 > -dy_ext;
  assign step_y = e2 < dx_ext;

  always_comb begin
    error_term_next = error_term;
    if (step_x) error_term_next = error_term_next - err_t'(ERR_BITS'(abs_dy));
    if (step_y) error_term_next = error_term_next + err_t'(ERR_BITS'(abs_dx));
  end

  assign prod_full = cfg.frame_width * cur_y;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      target_x        <= '0;
      target_y        <= '0;
      abs_dx          <= '0;
      abs_dy          <= '0;
      x_step_negative <= 1'b0;
      y_step_negative <= 1'b0;
      error_term      <= '0;
      held_color      <= '0;
      busy            <= 1'b0;
    end else if (pop && q_cmd.is_start) begin
      cur_x           <= q_cmd.x0;
      cur_y           <= q_cmd.y0;
      target_x        <= q_cmd.x1;
      target_y        <= q_cmd.y1;
      abs_dx          <= q_cmd.abs_dx;
      abs_dy          <= q_cmd.abs_dy;
      x_step_negative <= q_cmd.x_neg;
      y_step_negative <= q_cmd.y_neg;
      error_term      <= q_cmd.err;
      held_color      <= q_cmd.color;
      busy            <= 1'b1;
    end else if (emit) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        error_term <= error_term_next;
        if (step_x) cur_x <= x_step_negative ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
        if (step_y) cur_y <= y_step_negative ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end
    end
  end

  // pixel stage: product and base plus 4x
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && emit) begin
      s1_x      <= cur_x;
      s1_y      <= cur_y;
      s1_color  <= held_color;
      s1_last   <= at_end;
      s1_prod   <= ADDR_BITS'(prod_full);
      s1_base4x <= cfg.frame_base + ADDR_BITS'({cur_x, 2'b00});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      pixel_x       <= s1_x;
      pixel_y       <= s1_y;
      pixel_color   <= s1_color;
      last_pixel    <= s1_last;
      pixel_address <= s1_base4x + {s1_prod[ADDR_BITS-3:0], 2'b00};
    end
  end

  `BLR_ASSERT_NEXT(a_start_sets_busy, clk, rst, pop && q_cmd.is_start, busy, "start did not set busy")
  `BLR_ASSERT_NEXT(a_end_clears_busy, clk, rst, emit && at_end, !busy, "end point left busy set")
  `BLR_ASSERT_NEXT(a_no_pixel_when_idle, clk, rst, s1_en && !emit, !s1_valid, "pixel made without a step")
  `BLR_ASSERT_IMPL(a_pop_needs_room, clk, rst, pop, s1_en, "queue popped while pixel stage held")

endmodule

FILE: design/bresenham_line_rasterizer.sv
// top level of the all-octant bresenham line rasterizer
// depends on blr_pkg, blr_regs, blr_front, blr_queue, blr_back
//
//   channel  handshake              payload
//   input    in_valid / in_stall    op, start_x, start_y, end_x, end_y, line_color
//   output   out_valid / out_stall  pixel_x, pixel_y, pixel_address, pixel_color, last_pixel
//   config   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one word per cycle in and up to one pixel per cycle out, sustained while out_stall is low
// a step word goes through queue, address stage and output register before its pixel shows
// the address stage holds the single frame_width by y multiplier
// in_stall rises when the two-word queue is full; out_stall holds every pixel already in flight
// synchronous reset clears control, frame_width to 640, frame_base to 0; no clearing pass
module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  coord_t                start_x,
  input  coord_t                start_y,
  input  coord_t                end_x,
  input  coord_t                end_y,
  input  logic [COLOR_BITS-1:0] line_color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output coord_t                pixel_x,
  output coord_t                pixel_y,
  output logic [ADDR_BITS-1:0]  pixel_address,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t q_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  blr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  blr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  blr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

endmodule

FILE: dv/blr_pixel_checker.sv
`timescale 1ns / 100ps
// pixel checker for the line rasterizer: follows frame register writes, traces each line
// word by word and compares every pixel the block hands out with the traced one
// depends on blr_pkg
module blr_pixel_checker
  import blr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  op,
  input  coord_t                start_x,
  input  coord_t                start_y,
  input  coord_t                end_x,
  input  coord_t                end_y,
  input  logic [COLOR_BITS-1:0] line_color,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  coord_t                pixel_x,
  input  coord_t                pixel_y,
  input  logic [ADDR_BITS-1:0]  pixel_address,
  input  logic [COLOR_BITS-1:0] pixel_color,
  input  logic                  last_pixel,
  output int                    errors,
  output int                    pending,
  output int                    pixels_seen
);

  typedef struct {
    coord_t                x;
    coord_t                y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  pixel_t                expected_pixels[$];
  logic [WIDTH_BITS-1:0] row_pixels;
  logic [ADDR_BITS-1:0]  base_addr;
  coord_t                cur_x, cur_y, tgt_x, tgt_y, span_x, span_y;
  logic                  x_back, y_back, drawing;
  err_t                  err;
  logic [COLOR_BITS-1:0] held_color;

  task automatic trace_word();
    pixel_t px;
    int     e, e2;
    if (op == OP_START) begin
      cur_x      = start_x;
      cur_y      = start_y;
      tgt_x      = end_x;
      tgt_y      = end_y;
      x_back     = !(start_x < end_x);
      y_back     = !(start_y < end_y);
      span_x     = x_back ? start_x - end_x : end_x - start_x;
      span_y     = y_back ? start_y - end_y : end_y - start_y;
      err        = err_t'(int'(span_x) - int'(span_y));
      held_color = line_color;
      drawing    = 1'b1;
    end else if (drawing) begin
      px.x     = cur_x;
      px.y     = cur_y;
      px.addr  = base_addr
               + ((ADDR_BITS'(cur_x) + ADDR_BITS'(row_pixels) * ADDR_BITS'(cur_y)) << 2);
      px.color = held_color;
      px.last  = (cur_x == tgt_x) && (cur_y == tgt_y);
      expected_pixels.push_back(px);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        e  = int'(err);
        e2 = 2 * e;
        if (e2 > -int'(span_y)) begin
          e     = e - int'(span_y);
          cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < int'(span_x)) begin
          e     = e + int'(span_x);
          cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        err = err_t'(e);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      expected_pixels.delete();
      row_pixels  = FRAME_WIDTH_RESET;
      base_addr   = FRAME_BASE_RESET;
      cur_x       = '0;
      cur_y       = '0;
      tgt_x       = '0;
      tgt_y       = '0;
      span_x      = '0;
      span_y      = '0;
      x_back      = 1'b0;
      y_back      = 1'b0;
      err         = '0;
      held_color  = '0;
      drawing     = 1'b0;
      errors      = 0;
      pixels_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == (PADDR_BITS'(REG_FRAME_WIDTH) << 2)) begin
          row_pixels = pwdata[WIDTH_BITS-1:0];
        end else if (paddr == (PADDR_BITS'(REG_FRAME_BASE) << 2)) begin
          base_addr = pwdata[ADDR_BITS-1:0];
        end
      end
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: pixel with none expected, actual x %0d y %0d addr %0h", $time,
                   pixel_x, pixel_y, pixel_address);
        end else begin
          px = expected_pixels.pop_front();
          compare_field("pixel_x", 32'(px.x), 32'(pixel_x));
          compare_field("pixel_y", 32'(px.y), 32'(pixel_y));
          compare_field("pixel_address", px.addr, pixel_address);
          compare_field("pixel_color", px.color, pixel_color);
          compare_field("last_pixel", 32'(px.last), 32'(last_pixel));
        end
      end
      if (in_valid && !in_stall) begin
        trace_word();
      end
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: dv/bresenham_line_rasterizer_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the line rasterizer: directed lines, then random lines over
// several frame settings with random gaps on both channels
// depends on blr_pkg, bresenham_line_rasterizer and blr_pixel_checker
module bresenham_line_rasterizer_test;
  import blr_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 213;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 400;
  localparam logic [PADDR_BITS-1:0] WIDTH_ADDR = PADDR_BITS'(REG_FRAME_WIDTH) << 2;
  localparam logic [PADDR_BITS-1:0] BASE_ADDR  = PADDR_BITS'(REG_FRAME_BASE) << 2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel, penable, pwrite, pready;
  logic [PADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0]  pwdata, prdata;
  logic                  in_valid, in_stall, op;
  coord_t                start_x, start_y, end_x, end_y;
  logic [COLOR_BITS-1:0] line_color;
  logic                  out_valid, out_stall;
  coord_t                pixel_x, pixel_y;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;
  int                    errors, pending, pixels_seen;
  int                    words;
  int                    line_left;
  bit                    no_gaps;

  bresenham_line_rasterizer DUT (.*);
  blr_pixel_checker pixel_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_word(input logic kind, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic [COLOR_BITS-1:0] c);
    int gap, ddx, ddy;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= kind;
    start_x    <= sx;
    start_y    <= sy;
    end_x      <= ex;
    end_y      <= ey;
    line_color <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == OP_START) begin
      ddx       = int'(ex) - int'(sx);
      ddy       = int'(ey) - int'(sy);
      ddx       = ddx < 0 ? -ddx : ddx;
      ddy       = ddy < 0 ? -ddy : ddy;
      line_left = (ddx > ddy ? ddx : ddy) + 1;
      words++;
    end else if (line_left > 0) begin
      line_left--;
      words++;
    end
  endtask

  // hold the sender until every traced pixel is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic coord_t near(input coord_t c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  initial begin : pixel_sink
    int hold;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                    phase, goal, kind, r, span, steps;
    logic [WIDTH_BITS-1:0] w;
    logic [ADDR_BITS-1:0]  b;
    coord_t                x0, y0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    op         = OP_STEP;
    start_x    = '0;
    start_y    = '0;
    end_x      = '0;
    end_y      = '0;
    line_color = '0;
    words      = 0;
    line_left  = 0;
    no_gaps    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step while idle, single-pixel lines, corner to corner with restarts, then two short lines
    send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 0, 32'h0);
    send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_START, 4095, 4095, 4095, 4095, 32'hffff_ffff);
    send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_START, 0, 4095, 4095, 0, 32'ha5a5_a5a5);
    repeat (2) send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_START, 4095, 0, 0, 4095, 32'h5a5a_5a5a);
    repeat (2) send_word(OP_STEP, 4095, 4095, 4095, 4095, 32'hffff_ffff);
    send_word(OP_START, 100, 100, 98, 103, 32'h1234_5678);
    repeat (4) send_word(OP_STEP, 0, 0, 0, 0, 0);
    send_word(OP_START, 5, 7, 8, 7, 32'h8765_4321);
    repeat (4) send_word(OP_STEP, 0, 0, 0, 0, 0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          w = 1;
          b = '0;
        end
        1: begin
          w = 4096;
          b = 32'hffff_ffff;
        end
        2: begin
          w = '1;
          b = $urandom;
        end
        3: begin
          w = '0;
          b = 32'hffff_f000;
        end
        4: begin
          w = WIDTH_BITS'($urandom_range(1, 4096));
          b = $urandom;
        end
        default: begin
          w = WIDTH_BITS'($urandom_range(2, 100));
          b = $urandom;
        end
      endcase
      write_reg(WIDTH_ADDR, DATA_BITS'(w));
      write_reg(BASE_ADDR, b);
      goal = words + PHASE_WORDS;
      while (words < goal) begin
        if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          send_word(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), $urandom);
        end else begin
          r    = $urandom_range(0, 99);
          span = r < 85 ? 8 : (r < 99 ? 40 : 300);
          x0   = coord_t'($urandom_range(0, 4095));
          y0   = coord_t'($urandom_range(0, 4095));
          send_word(OP_START, x0, y0, near(x0, span), near(y0, span), $urandom);
          steps = line_left;
          if (kind < 16) begin
            steps = $urandom_range(0, steps);
          end else if (kind < 24) begin
            steps = steps + $urandom_range(1, 2);
          end
          repeat (steps) begin
            send_word(OP_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), $urandom);
          end
          if ($urandom_range(0, 39) == 0) settle();
        end
      end
    end
    settle();

    $display("covered %0d line words over %0d frame settings, %0d pixels compared",
             words, PHASES + 1, pixels_seen);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
